@@ design/utf8_space_collapsing_truncator_top_macros.svh @@
// assertion macros shared by the truncator checker
`ifndef UTF8_SPACE_COLLAPSING_TRUNCATOR_TOP_MACROS_SVH
`define UTF8_SPACE_COLLAPSING_TRUNCATOR_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("truncator assertion failed");

// next-cycle implication, off during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("truncator assertion failed");

`endif

@@ design/utf8sct_pkg.sv @@
// types, constants and the lead byte decoder of the utf8 truncator
`default_nettype none
package utf8sct_pkg;

  localparam int COUNT_BITS    = 16;
  localparam int CFG_BITS      = 16;
  localparam int CMP_BITS      = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;
  localparam int HELD_DEPTH    = 5;
  localparam int BURST_BYTES   = HELD_DEPTH + 1;
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

  localparam logic [CFG_BITS-1:0] MAX_CHARS_RESET = CFG_BITS'(50);

  localparam logic [7:0] BYTE_NUL   = 8'h00;
  localparam logic [7:0] BYTE_CR    = 8'h0d;
  localparam logic [7:0] BYTE_LF    = 8'h0a;
  localparam logic [7:0] BYTE_TAB   = 8'h09;
  localparam logic [7:0] BYTE_SPACE = 8'h20;

  typedef logic [2:0] len_t;

  // one finished output run: up to six bytes, emitted from index 0 up
  typedef struct packed {
    logic [BURST_BYTES-1:0][7:0] bytes;
    len_t                        len;
  } burst_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  // byte count of a utf8 sequence from its lead byte, zero when invalid
  function automatic len_t lead_length(input logic [7:0] b);
    len_t len;
    if ((b & 8'h80) == 8'h00) begin
      len = 3'd1;
    end else if ((b & 8'he0) == 8'hc0) begin
      len = 3'd2;
    end else if ((b & 8'hf0) == 8'he0) begin
      len = 3'd3;
    end else if ((b & 8'hf8) == 8'hf0) begin
      len = 3'd4;
    end else if ((b & 8'hfc) == 8'hf8) begin
      len = 3'd5;
    end else if ((b & 8'hfe) == 8'hfc) begin
      len = 3'd6;
    end else begin
      len = 3'd0;
    end
    return len;
  endfunction

endpackage
`default_nettype wire

@@ design/utf8_space_collapsing_truncator_top.sv @@
// Top level of the utf8 space-collapsing truncator.
// Input stream s_*: one string byte per beat, a zero byte ends the string.
// Output stream m_*: copied bytes; m_tlast marks the last byte produced by
// one input byte (a whole utf8 character, a space, or the zero terminator).
// cfg_*: writes max_chars, always ready; write only while the block is idle.
// A character is queued whole once its last byte arrives, and the output
// stage sends it one byte per cycle while m_tready is high, so a beat that
// completes something passes the queue and output register before m_*.
// Throughput: one input byte per cycle while the queue is not full; the
// output serialiser sends one byte per cycle while m_tready is high, so
// a six-byte character holds it while the four-run queue absorbs input.
// When m_tready is low the current byte holds on m_*, the queue fills and
// s_tready drops only once all four queue slots are taken.
// Reset (rst, synchronous): queue and output emptied, max_chars back to 50,
// string state back to start of string with leading spaces suppressed.
`default_nettype none
module utf8_space_collapsing_truncator_top (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [7:0]                       s_tdata,   // [7:0] data_byte
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [7:0]                            m_tdata,   // [7:0] out_byte
  output logic                                  m_tlast,   // run_last
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [utf8sct_pkg::CFG_BITS-1:0] cfg_data   // max_chars
);
  import utf8sct_pkg::*;

  fifo_status_t q_status;
  burst_t       push_burst;
  burst_t       head;
  logic         push;
  logic         pop;

  utf8sct_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .q_status   (q_status),
    .push       (push),
    .push_burst (push_burst)
  );

  utf8sct_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_burst (push_burst),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  utf8sct_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
`default_nettype wire

@@ design/utf8sct_fifo.sv @@
// small queue of finished runs between the classifier and the serialiser
`default_nettype none
module utf8sct_fifo (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      push,
  input  wire utf8sct_pkg::burst_t       push_burst,
  input  wire logic                      pop,
  output utf8sct_pkg::burst_t            head,
  output utf8sct_pkg::fifo_status_t      status
);
  import utf8sct_pkg::*;

  burst_t                   mem [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr;
  logic [FIFO_PTR_BITS-1:0] rd_ptr;
  logic [FIFO_PTR_BITS:0]   count;

  assign status.full  = (count == (FIFO_PTR_BITS+1)'(FIFO_DEPTH));
  assign status.empty = (count == '0);
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_burst;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ design/utf8sct_front.sv @@
// input side: takes bytes, tracks string state and queues finished runs
`default_nettype none
module utf8sct_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [7:0]                     s_tdata,   // [7:0] data_byte
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [utf8sct_pkg::CFG_BITS-1:0] cfg_data,  // max_chars
  input  wire utf8sct_pkg::fifo_status_t      q_status,
  output logic                                push,
  output utf8sct_pkg::burst_t                 push_burst
);
  import utf8sct_pkg::*;

  logic [CFG_BITS-1:0]   max_chars;
  logic [7:0]            held_bytes [HELD_DEPTH];
  len_t                  bytes_still_needed, bytes_still_needed_next;
  len_t                  held_count, held_count_next;
  logic [COUNT_BITS-1:0] items_emitted, items_emitted_next;
  logic                  suppress_space, suppress_space_next;
  logic                  halted, halted_next;

  logic       accept;
  logic [7:0] b;
  len_t       lead_len;
  logic       limit_hit;
  logic       hold_we;
  len_t       hold_idx;
  logic       count_up;

  assign s_tready  = !q_status.full;
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign b         = s_tdata;
  assign lead_len  = lead_length(b);
  assign limit_hit = CMP_BITS'(items_emitted) >= CMP_BITS'(max_chars);

  always_comb begin
    bytes_still_needed_next = bytes_still_needed;
    held_count_next         = held_count;
    suppress_space_next     = suppress_space;
    halted_next             = halted;
    push                    = 1'b0;
    hold_we                 = 1'b0;
    hold_idx                = held_count;
    count_up                = 1'b0;
    if (accept) begin
      if (b == BYTE_NUL) begin
        push                    = (max_chars != '0);
        bytes_still_needed_next = '0;
        held_count_next         = '0;
        suppress_space_next     = 1'b1;
        halted_next             = 1'b0;
      end else if (bytes_still_needed != '0) begin
        // any nonzero byte continues an open character
        if (bytes_still_needed == 3'd1) begin
          push                    = 1'b1;
          count_up                = 1'b1;
          held_count_next         = '0;
          bytes_still_needed_next = '0;
          suppress_space_next     = 1'b0;
        end else begin
          hold_we                 = (held_count < len_t'(HELD_DEPTH));
          held_count_next         = held_count + 3'd1;
          bytes_still_needed_next = bytes_still_needed - 3'd1;
        end
      end else if (halted || limit_hit) begin
        // copying stopped until the terminator
      end else if (b == BYTE_CR || b == BYTE_LF || b == BYTE_TAB) begin
        // dropped
      end else if (b == BYTE_SPACE) begin
        if (!suppress_space) begin
          push                = 1'b1;
          count_up            = 1'b1;
          suppress_space_next = 1'b1;
        end
      end else if (lead_len == 3'd0) begin
        halted_next = 1'b1;
      end else if (lead_len == 3'd1) begin
        push                = 1'b1;
        count_up            = 1'b1;
        suppress_space_next = 1'b0;
      end else begin
        hold_we                 = 1'b1;
        hold_idx                = '0;
        held_count_next         = 3'd1;
        bytes_still_needed_next = lead_len - 3'd1;
      end
    end
  end

  always_comb begin
    items_emitted_next = items_emitted;
    if (accept && b == BYTE_NUL) begin
      items_emitted_next = '0;
    end else if (count_up && items_emitted != '1) begin
      items_emitted_next = items_emitted + 1'b1;
    end
  end

  // held bytes first, then the byte that closes the run
  always_comb begin
    for (int i = 0; i < BURST_BYTES; i++) begin
      push_burst.bytes[i] = b;
    end
    for (int i = 0; i < HELD_DEPTH; i++) begin
      if (b != BYTE_NUL && len_t'(i) < held_count) begin
        push_burst.bytes[i] = held_bytes[i];
      end
    end
    push_burst.len = (b == BYTE_NUL) ? 3'd1 : held_count + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (hold_we) begin
      held_bytes[hold_idx] <= b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_chars          <= MAX_CHARS_RESET;
      bytes_still_needed <= '0;
      held_count         <= '0;
      items_emitted      <= '0;
      suppress_space     <= 1'b1;
      halted             <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_chars <= cfg_data;
      end
      bytes_still_needed <= bytes_still_needed_next;
      held_count         <= held_count_next;
      items_emitted      <= items_emitted_next;
      suppress_space     <= suppress_space_next;
      halted             <= halted_next;
    end
  end

endmodule
`default_nettype wire

@@ design/utf8sct_back.sv @@
// output side: serialises queued runs one byte per beat
`default_nettype none
module utf8sct_back (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire utf8sct_pkg::fifo_status_t q_status,
  input  wire utf8sct_pkg::burst_t       head,
  output logic                           pop,
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic [7:0]                     m_tdata,   // [7:0] out_byte
  output logic                           m_tlast    // run_last
);
  import utf8sct_pkg::*;

  burst_t cur;
  logic   cur_valid;
  len_t   idx;
  logic   last_beat;

  assign last_beat = (idx == cur.len - 3'd1);
  assign pop       = !q_status.empty && (!cur_valid || (m_tready && last_beat));
  assign m_tvalid  = cur_valid;
  assign m_tdata   = cur.bytes[idx];
  assign m_tlast   = last_beat;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (cur_valid && m_tready) begin
      if (last_beat) begin
        cur_valid <= 1'b0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

endmodule
`default_nettype wire

@@ design/utf8sct_checker.sv @@
// port-level checks for the truncator, bound to the top level
`default_nettype none
`include "utf8_space_collapsing_truncator_top_macros.svh"
module utf8sct_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic       m_tlast
);

  // a stalled output beat holds
  `ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

  // a zero byte is only ever the terminator, which closes its run
  `ASSERT_IMPLY(a_nul_last, clk, rst, m_tvalid && m_tdata == 8'h00, m_tlast)

  // nothing left on the output after reset
  `ASSERT_IMPLY(a_reset_empty, clk, rst, $past(rst), !m_tvalid)

endmodule

bind utf8_space_collapsing_truncator_top utf8sct_checker u_checker (.*);
`default_nettype wire

@@ bench/utf8_space_collapsing_truncator_top_test.sv @@
// self-checking testbench of the utf8 space-collapsing truncator
`timescale 1ns / 100ps
module utf8_space_collapsing_truncator_top_test;
  import utf8sct_pkg::*;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } out_beat_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [7:0]          s_tdata = 8'h00;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [7:0]          m_tdata;
  logic                m_tlast;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_BITS-1:0] cfg_data = '0;

  // bytes waiting to be offered, and copied bytes still owed by the block
  logic [7:0] raw_bytes [$];
  out_beat_t  copied_due [$];

  // predictor state
  logic [CFG_BITS-1:0]   lim;
  logic [7:0]            held_part [5];
  logic [2:0]            need_left;
  logic [2:0]            held_n;
  logic [COUNT_BITS-1:0] emitted;
  logic                  quiet_space;
  logic                  stopped;

  int        gap_left = 0;
  int        burst_left = 0;
  int        beats_in = 0;
  int        beats_out = 0;
  int        strings_seen = 0;
  int        settings_used = 1;
  int        errors = 0;
  int        rx_mode = 0;
  int        rx_mode_left = 0;
  int        rx_tick = 0;
  int        hold_left = 0;
  logic      hold_done = 1'b0;
  out_beat_t want;

  // opening strings: space rules and dropped controls, a two-byte and a
  // six-byte character with odd continuations, an invalid lead, a cut-off
  logic [7:0] opening [26] = '{
    8'h20, 8'h41, 8'h20, 8'h20, 8'h09, 8'h0d, 8'h0a, 8'h42, 8'h00,
    8'hc3, 8'ha9, 8'hfc, 8'h80, 8'h20, 8'h0d, 8'h81, 8'h82, 8'h7f, 8'h00,
    8'h41, 8'hff, 8'h42, 8'h00,
    8'he2, 8'h82, 8'h00
  };

  utf8_space_collapsing_truncator_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic int seq_len(input logic [7:0] b);
    int n;
    casez (b)
      8'b0???????: n = 1;
      8'b110?????: n = 2;
      8'b1110????: n = 3;
      8'b11110???: n = 4;
      8'b111110??: n = 5;
      8'b1111110?: n = 6;
      default:     n = 0;
    endcase
    return n;
  endfunction

  task automatic restart_string();
    int i;
    for (i = 0; i < 5; i++) held_part[i] = 8'h00;
    need_left   = 3'd0;
    held_n      = 3'd0;
    emitted     = '0;
    quiet_space = 1'b1;
    stopped     = 1'b0;
  endtask

  task automatic bump_count();
    if (emitted != {COUNT_BITS{1'b1}}) emitted = emitted + 1'b1;
  endtask

  task automatic truncate_byte(input logic [7:0] b);
    logic [7:0] run [$];
    int         i;
    int         len;
    if (b == BYTE_NUL) begin
      if (lim != 0) run.push_back(BYTE_NUL);
      restart_string();
      strings_seen++;
    end else if (need_left != 3'd0) begin
      // mid-character: any nonzero byte is taken as the next byte
      if (need_left == 3'd1) begin
        for (i = 0; i < held_n && i < 5; i++) run.push_back(held_part[i]);
        run.push_back(b);
        held_n      = 3'd0;
        need_left   = 3'd0;
        bump_count();
        quiet_space = 1'b0;
      end else begin
        if (held_n < 3'd5) held_part[held_n] = b;
        held_n    = held_n + 3'd1;
        need_left = need_left - 3'd1;
      end
    end else if (stopped || emitted >= lim) begin
    end else if (b == BYTE_CR || b == BYTE_LF || b == BYTE_TAB) begin
    end else if (b == BYTE_SPACE) begin
      if (!quiet_space) begin
        run.push_back(b);
        bump_count();
        quiet_space = 1'b1;
      end
    end else begin
      len = seq_len(b);
      if (len == 0) begin
        stopped = 1'b1;
      end else if (len == 1) begin
        run.push_back(b);
        bump_count();
        quiet_space = 1'b0;
      end else begin
        held_part[0] = b;
        held_n       = 3'd1;
        need_left    = 3'(len - 1);
      end
    end
    for (i = 0; i < run.size(); i++)
      copied_due.push_back('{out_byte: run[i], run_last: (i == run.size() - 1)});
  endtask

  function automatic logic [7:0] lead_of(input int len);
    logic [7:0] r;
    r = 8'($urandom);
    case (len)
      2:       r = {3'b110, r[4:0]};
      3:       r = {4'b1110, r[3:0]};
      4:       r = {5'b11110, r[2:0]};
      5:       r = {6'b111110, r[1:0]};
      default: r = {7'b1111110, r[0]};
    endcase
    return r;
  endfunction

  function automatic logic [7:0] cont_byte();
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(1, 255));
    return {2'b10, 6'($urandom)};
  endfunction

  // random strings, mostly well formed, until the byte budget is used up
  task automatic gen_strings(input int budget);
    logic [7:0] str [$];
    int         made;
    int         units;
    int         u;
    int         k;
    int         len;
    int         pick;
    made = 0;
    while (made < budget) begin
      str.delete();
      units = $urandom_range(1, 12);
      for (u = 0; u < units; u++) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          if ($urandom_range(0, 4) == 0) str.push_back(8'($urandom_range(1, 127)));
          else str.push_back(8'($urandom_range(33, 126)));
        end else if (pick < 58) begin
          k = $urandom_range(1, 3);
          repeat (k) str.push_back(BYTE_SPACE);
        end else if (pick < 65) begin
          k = $urandom_range(0, 2);
          str.push_back(k == 0 ? BYTE_CR : (k == 1 ? BYTE_LF : BYTE_TAB));
        end else if (pick < 96) begin
          len = $urandom_range(2, 6);
          str.push_back(lead_of(len));
          repeat (len - 1) str.push_back(cont_byte());
        end else begin
          k = $urandom_range(0, 3);
          str.push_back(k == 0 ? 8'hfe : (k == 1 ? 8'hff : {2'b10, 6'($urandom)}));
        end
      end
      // character cut off by the terminator
      if ($urandom_range(0, 9) == 0) begin
        len = $urandom_range(2, 6);
        str.push_back(lead_of(len));
        repeat ($urandom_range(0, len - 2)) str.push_back(cont_byte());
      end
      str.push_back(BYTE_NUL);
      foreach (str[u]) raw_bytes.push_back(str[u]);
      made += str.size();
    end
  endtask

  task automatic wait_idle();
    do begin
      while (raw_bytes.size() != 0 || s_tvalid || copied_due.size() != 0) @(posedge clk);
      // bytes that produce nothing may still be in flight
      repeat (20) @(posedge clk);
    end while (raw_bytes.size() != 0 || s_tvalid || copied_due.size() != 0);
  endtask

  task automatic write_max_chars(input logic [CFG_BITS-1:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic run_phase(input logic [CFG_BITS-1:0] v, input int budget);
    write_max_chars(v);
    gen_strings(budget);
  endtask

  // sender: bursts of random length with random gaps, predicts at each beat
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid   <= 1'b0;
      lim        = MAX_CHARS_RESET;
      restart_string();
      gap_left   = 0;
      burst_left = 0;
    end else begin
      if (cfg_valid && cfg_ready) lim = cfg_data;
      if (s_tvalid && s_tready) begin
        truncate_byte(s_tdata);
        beats_in <= beats_in + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (raw_bytes.size() != 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= raw_bytes.pop_front();
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
          end else begin
            burst_left--;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern switching between modes, plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      rx_tick++;
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(8, 40);
      end else begin
        rx_mode_left--;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!hold_done && beats_in >= 45) begin
        hold_done = 1'b1;
        hold_left = 100;
        m_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= 1'($urandom_range(0, 1));
          2:       m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= (rx_tick % 5) >= 2;
        endcase
      end
    end
  end

  // monitor: every output beat against the oldest owed byte
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      beats_out++;
      if (copied_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none, got byte %02h last %0b",
                 $time, m_tdata, m_tlast);
      end else begin
        want = copied_due.pop_front();
        if (want.out_byte !== m_tdata || want.run_last !== m_tlast) begin
          errors++;
          $display("%0t: mismatch, expected byte %02h last %0b, got byte %02h last %0b",
                   $time, want.out_byte, want.run_last, m_tdata, m_tlast);
        end
      end
    end
  end

  initial begin
    foreach (opening[i]) raw_bytes.push_back(opening[i]);
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    run_phase(16'hffff, 60);
    run_phase(16'd0, 25);
    run_phase(16'd1, 35);
    run_phase(16'd3, 35);
    run_phase(16'($urandom_range(2, 12)), 50);
    run_phase(MAX_CHARS_RESET, 45);
    wait_idle();
    if (copied_due.size() != 0) begin
      errors++;
      $display("%0t: %0d owed bytes never arrived", $time, copied_due.size());
    end
    $display("covered %0d input beats in %0d strings over %0d max_chars settings",
             beats_in, strings_seen, settings_used);
    $display("checked %0d output beats, %0d mismatches", beats_out, errors);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("timeout with %0d owed bytes", copied_due.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/utf8sct_pkg.sv
design/utf8sct_fifo.sv
design/utf8sct_front.sv
design/utf8sct_back.sv
design/utf8_space_collapsing_truncator_top.sv
design/utf8sct_checker.sv
bench/utf8_space_collapsing_truncator_top_test.sv
